>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pcts_pkg.sv
`timescale 1ns / 1ps

package pcts_pkg;

  typedef enum logic [2:0] {
    ST_READY     = 3'd0,
    ST_WAIT_SYNC = 3'd1,
    ST_WAIT_ZERO = 3'd2,
    ST_TEST      = 3'd3,
    ST_FINISHED  = 3'd4
  } state_t;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_ZERO   = 3'd3;
  localparam logic [2:0] CMD_UPDATE = 3'd4;

  localparam logic [1:0] REG_WORK_MODE   = 2'd0;
  localparam logic [1:0] REG_DURATION_MS = 2'd1;
  localparam logic [1:0] REG_MAX_RUN_S   = 2'd2;
  localparam logic [1:0] REG_ANGLE_DEG   = 2'd3;

  localparam logic [1:0] MODE_TIMED      = 2'd0;
  localparam logic [1:0] MODE_CONTINUOUS = 2'd1;
  localparam logic [1:0] MODE_FIRST_WAVE = 2'd2;

  localparam logic [7:0]  ANGLE_MIN        = 8'd5;
  localparam logic [7:0]  ANGLE_MAX        = 8'd175;
  localparam logic [7:0]  ANGLE_DEFAULT    = 8'd90;
  localparam logic [9:0]  MS_PER_S         = 10'd1000;
  localparam logic [31:0] DURATION_DEFAULT = 32'd1000;
  localparam logic [32:0] MAX_RUN_MS_DEFAULT = 33'd60000;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    state_t      run_state;
    logic        fire_enable;
    logic        fire_pulse;
    logic [31:0] elapsed_out;
    logic [31:0] crossings_total;
    logic        ready_lamp;
    logic        alarm_lamp;
    logic        idle;
  } result_t;

endpackage

>>> rtl/phase_control_test_sequencer_unit.sv
// Phase-control test sequencer: one result for every input transfer.
// The result is registered in the output register, or in the skid register while that is stalled.
// Throughput: one item per cycle; an output register plus a skid register
// let input transfers continue while a result waits, and in_stall rises only
// when both hold a result. Synchronous active-high reset returns the run state,
// counters, LED latches, configuration registers and valid flags to their defaults at once.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module phase_control_test_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic        sync_present,
  input  logic        main_view,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  run_state,
  output logic        fire_enable,
  output logic        fire_pulse,
  output logic [31:0] elapsed_out,
  output logic [31:0] crossings_total,
  output logic        ready_lamp,
  output logic        alarm_lamp,
  output logic        idle,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [1:0]  work_mode;
  logic [31:0] duration_ms;
  logic [32:0] max_run_ms;
  logic [7:0]  angle_deg;
  logic [7:0]  angle_wr;

  pcts_pkg::state_t phase_state;
  pcts_pkg::state_t phase_state_next;
  logic        firing_on;
  logic        firing_on_next;
  logic [31:0] elapsed_ms;
  logic [31:0] elapsed_ms_next;
  logic        first_wave_done;
  logic        first_wave_done_next;
  logic [31:0] crossing_count;
  logic [31:0] crossing_count_next;
  logic        ready_lit;
  logic        ready_lit_next;
  logic        alarm_lit;
  logic        alarm_lit_next;
  logic        pulse;

  pcts_pkg::result_t res;
  pcts_pkg::result_t res_q;
  pcts_pkg::result_t skid_q;
  logic              skid_valid;
  logic              accept;
  logic              out_free;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (cfg_data[7:0] < pcts_pkg::ANGLE_MIN) begin
      angle_wr = pcts_pkg::ANGLE_MIN;
    end else if (cfg_data[7:0] > pcts_pkg::ANGLE_MAX) begin
      angle_wr = pcts_pkg::ANGLE_MAX;
    end else begin
      angle_wr = cfg_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_mode   <= pcts_pkg::MODE_TIMED;
      duration_ms <= pcts_pkg::DURATION_DEFAULT;
      max_run_ms  <= pcts_pkg::MAX_RUN_MS_DEFAULT;
      angle_deg   <= pcts_pkg::ANGLE_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        pcts_pkg::REG_WORK_MODE: begin
          work_mode <= cfg_data[1:0];
        end
        pcts_pkg::REG_DURATION_MS: begin
          duration_ms <= cfg_data;
        end
        pcts_pkg::REG_MAX_RUN_S: begin
          max_run_ms <= 33'(cfg_data[22:0]) * 33'(pcts_pkg::MS_PER_S);
        end
        pcts_pkg::REG_ANGLE_DEG: begin
          angle_deg <= angle_wr;
        end
        default: begin
        end
      endcase
    end
  end

  // Next state of the run for the item at the input.
  always_comb begin
    logic dur_hit;
    logic max_hit;
    dur_hit = (work_mode != pcts_pkg::MODE_CONTINUOUS) && (elapsed_ms >= duration_ms);
    max_hit = {1'b0, elapsed_ms} >= max_run_ms;

    phase_state_next     = phase_state;
    firing_on_next       = firing_on;
    elapsed_ms_next      = elapsed_ms;
    first_wave_done_next = first_wave_done;
    crossing_count_next  = crossing_count;
    ready_lit_next       = ready_lit;
    alarm_lit_next       = alarm_lit;
    pulse                = 1'b0;

    case (command)
      pcts_pkg::CMD_TICK: begin
        if (elapsed_ms != pcts_pkg::COUNT_MAX) begin
          elapsed_ms_next = elapsed_ms + 32'd1;
        end
      end
      pcts_pkg::CMD_START: begin
        if (phase_state == pcts_pkg::ST_READY && sync_present) begin
          elapsed_ms_next      = '0;
          first_wave_done_next = 1'b0;
          firing_on_next       = 1'b1;
          phase_state_next     = pcts_pkg::ST_WAIT_SYNC;
        end
      end
      pcts_pkg::CMD_STOP: begin
        firing_on_next   = 1'b0;
        phase_state_next = pcts_pkg::ST_READY;
      end
      pcts_pkg::CMD_ZERO: begin
        if (phase_state == pcts_pkg::ST_WAIT_ZERO) begin
          phase_state_next     = pcts_pkg::ST_TEST;
          elapsed_ms_next      = '0;
          first_wave_done_next = 1'b0;
          firing_on_next       = 1'b1;
        end
        if (phase_state_next == pcts_pkg::ST_TEST) begin
          pulse = (work_mode != pcts_pkg::MODE_FIRST_WAVE) || !first_wave_done_next;
          first_wave_done_next = 1'b1;
          if (crossing_count != pcts_pkg::COUNT_MAX) begin
            crossing_count_next = crossing_count + 32'd1;
          end
        end
      end
      pcts_pkg::CMD_UPDATE: begin
        if (!sync_present && phase_state != pcts_pkg::ST_READY) begin
          firing_on_next   = 1'b0;
          phase_state_next = pcts_pkg::ST_READY;
        end
        if (phase_state_next == pcts_pkg::ST_TEST && max_hit) begin
          firing_on_next   = 1'b0;
          phase_state_next = pcts_pkg::ST_READY;
        end
        ready_lit_next = (phase_state_next == pcts_pkg::ST_READY) && sync_present;
        alarm_lit_next = !sync_present;
        if (!main_view) begin
          if (phase_state_next == pcts_pkg::ST_TEST && dur_hit) begin
            firing_on_next   = 1'b0;
            phase_state_next = pcts_pkg::ST_READY;
          end
        end else begin
          case (phase_state_next)
            pcts_pkg::ST_WAIT_SYNC: begin
              if (sync_present) begin
                phase_state_next = pcts_pkg::ST_WAIT_ZERO;
              end
            end
            pcts_pkg::ST_TEST: begin
              if (dur_hit) begin
                phase_state_next = pcts_pkg::ST_FINISHED;
              end
            end
            pcts_pkg::ST_FINISHED: begin
              firing_on_next   = 1'b0;
              phase_state_next = pcts_pkg::ST_READY;
            end
            pcts_pkg::ST_READY, pcts_pkg::ST_WAIT_ZERO: begin
            end
            default: begin
              phase_state_next = pcts_pkg::ST_READY;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields, taken from the state after the item.
  always_comb begin
    res.run_state   = phase_state_next;
    res.fire_enable = firing_on_next;
    res.fire_pulse  = pulse;
    if (phase_state_next == pcts_pkg::ST_TEST || phase_state_next == pcts_pkg::ST_FINISHED) begin
      res.elapsed_out = elapsed_ms_next;
    end else begin
      res.elapsed_out = '0;
    end
    res.crossings_total = crossing_count_next;
    res.ready_lamp      = ready_lit_next;
    res.alarm_lamp      = alarm_lit_next;
    res.idle            = (phase_state_next == pcts_pkg::ST_READY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_state     <= pcts_pkg::ST_READY;
      firing_on       <= 1'b0;
      elapsed_ms      <= '0;
      first_wave_done <= 1'b0;
      crossing_count  <= '0;
      ready_lit       <= 1'b0;
      alarm_lit       <= 1'b0;
    end else if (accept) begin
      phase_state     <= phase_state_next;
      firing_on       <= firing_on_next;
      elapsed_ms      <= elapsed_ms_next;
      first_wave_done <= first_wave_done_next;
      crossing_count  <= crossing_count_next;
      ready_lit       <= ready_lit_next;
      alarm_lit       <= alarm_lit_next;
    end
  end

  // The skid register holds a result only while the output register is
  // stalled, so results leave in the order of their input transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        res_q <= skid_q;
      end else if (accept) begin
        res_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign run_state       = res_q.run_state;
  assign fire_enable     = res_q.fire_enable;
  assign fire_pulse      = res_q.fire_pulse;
  assign elapsed_out     = res_q.elapsed_out;
  assign crossings_total = res_q.crossings_total;
  assign ready_lamp      = res_q.ready_lamp;
  assign alarm_lamp      = res_q.alarm_lamp;
  assign idle            = res_q.idle;

  `ASSERT_ALWAYS(a_angle_range, (angle_deg >= pcts_pkg::ANGLE_MIN) && (angle_deg <= pcts_pkg::ANGLE_MAX), "Firing angle left its clamped range.")
  `ASSERT_ALWAYS(a_ready_firing, (phase_state == pcts_pkg::ST_READY) == !firing_on, "Firing enable disagrees with the run state.")
  `ASSERT_IMPLIES(a_skid_order, skid_valid, out_valid, "Skid register holds a result while the output register is empty.")
  `ASSERT_NEXT(a_skid_fill, accept && out_valid && out_stall, skid_valid, "Transfer during output stall was not kept in the skid register.")
  `ASSERT_NEXT(a_count_mono, 1'b1, crossing_count >= $past(crossing_count), "Zero-cross count decreased.")

endmodule
